// File: src/sss_pkg.sv
// Shared types, character codes and the signature test for the save-signature scanner.
// No dependencies.
`default_nettype none
package sss_pkg;

	localparam int WinDepth = 6;
	localparam int HoldDepth = WinDepth - 1;

	typedef logic [7:0] byte_t;
	typedef logic [WinDepth-1:0][7:0] window_t;
	typedef logic [2:0] count_t;

	typedef enum logic [2:0] {
		KIND_NONE       = 3'd0,
		KIND_EEPROM_8K  = 3'd1,
		KIND_SRAM_32K   = 3'd2,
		KIND_FLASH_64K  = 3'd3,
		KIND_FLASH_128K = 3'd4
	} save_kind_t;

	localparam byte_t CH_E   = 8'h45;
	localparam byte_t CH_P   = 8'h50;
	localparam byte_t CH_R   = 8'h52;
	localparam byte_t CH_O   = 8'h4F;
	localparam byte_t CH_M   = 8'h4D;
	localparam byte_t CH_S   = 8'h53;
	localparam byte_t CH_A   = 8'h41;
	localparam byte_t CH_F   = 8'h46;
	localparam byte_t CH_L   = 8'h4C;
	localparam byte_t CH_H   = 8'h48;
	localparam byte_t CH_ONE = 8'h31;

	// Test one start position; w[0] is the start byte, avail bytes exist from there.
	function automatic save_kind_t sig_test(input window_t w, input count_t avail);
		save_kind_t k;
		k = KIND_NONE;
		priority if (w[0] == CH_E) begin
			if (avail >= 3'd6 && w[1] == CH_E && w[2] == CH_P && w[3] == CH_R &&
					w[4] == CH_O && w[5] == CH_M)
				k = KIND_EEPROM_8K;
		end else if (w[0] == CH_S) begin
			if (avail >= 3'd4 && w[1] == CH_R && w[2] == CH_A && w[3] == CH_M)
				k = KIND_SRAM_32K;
		end else if (w[0] == CH_F) begin
			if (avail >= 3'd5 && w[1] == CH_L && w[2] == CH_A && w[3] == CH_S &&
					w[4] == CH_H) begin
				if (avail >= 3'd6 && w[5] == CH_ONE)
					k = KIND_FLASH_128K;
				else
					k = KIND_FLASH_64K;
			end
		end else begin
			k = KIND_NONE;
		end
		return k;
	endfunction

endpackage
`default_nettype wire

// File: src/sss_match.sv
// Signature match over the six-byte working window; picks the earliest start position.
// Depends on sss_pkg.
`default_nettype none
module sss_match (
	input  sss_pkg::window_t   cur,
	input  sss_pkg::count_t    count,
	input  logic               last,
	output sss_pkg::save_kind_t kind
);
	import sss_pkg::*;

	save_kind_t kind_at [WinDepth];
	window_t    slice   [WinDepth];
	count_t     avail   [WinDepth];

	always_comb begin
		for (int p = 0; p < WinDepth; p++) begin
			for (int k = 0; k < WinDepth; k++)
				slice[p][k] = (p + k < WinDepth) ? cur[(p + k) % WinDepth] : 8'd0;
			avail[p] = (3'(p) < count) ? count - 3'(p) : 3'd0;
			kind_at[p] = (avail[p] != 3'd0) ? sig_test(slice[p], avail[p]) : KIND_NONE;
		end
	end

	// On the last byte every start position with bytes present counts, lowest first;
	// otherwise only a full window is tested, at its oldest position.
	always_comb begin
		kind = KIND_NONE;
		if (last) begin
			for (int p = WinDepth - 1; p >= 0; p--)
				if (kind_at[p] != KIND_NONE)
					kind = kind_at[p];
		end else if (count == 3'(WinDepth)) begin
			kind = kind_at[0];
		end
	end

endmodule
`default_nettype wire

// File: src/save_signature_scanner_unit.sv
// Save-signature scanner: byte stream in, one save-kind result per image.
// Depends on sss_pkg and sss_match.
// Timing: an accepted byte is registered in s1; for a final byte the result then goes
// to the result register. Throughput: one byte per cycle unless a final byte waits on a
// full, stalled result register; set by the single s1-to-result window update.
// Reset clears the window fill, match state and both valid flags at once.
`default_nettype none
module save_signature_scanner_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] image_byte,
	input  logic       final_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       found,
	output logic [2:0] save_kind
);
	import sss_pkg::*;

	// input register
	logic  s1_valid_s1;
	byte_t s1_byte_s1;
	logic  s1_final_s1;

	// scan state: bytes not yet fully tested, oldest at index 0
	byte_t      win_q [HoldDepth];
	count_t     fill_q;
	logic       made_q;
	save_kind_t kind_q;

	// result register
	logic       res_valid_q;
	logic       found_q;
	save_kind_t res_kind_q;

	logic       adv;
	count_t     count;
	window_t    cur;
	save_kind_t hit;

	// The s1 byte moves on unless it is final and the result register cannot take it.
	assign adv       = s1_valid_s1 && (!s1_final_s1 || !res_valid_q || !res_stall);
	assign src_stall = s1_valid_s1 && !adv;

	// Working window: held bytes, the new byte appended at the fill point.
	assign count = fill_q + 3'd1;
	always_comb begin
		for (int i = 0; i < WinDepth; i++) begin
			if (i < HoldDepth && 3'(i) < fill_q)
				cur[i] = win_q[i % HoldDepth];
			else if (3'(i) == fill_q)
				cur[i] = s1_byte_s1;
			else
				cur[i] = 8'd0;
		end
	end

	sss_match u_match (
		.cur   (cur),
		.count (count),
		.last  (s1_final_s1),
		.kind  (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!s1_valid_s1 || adv) begin
			s1_valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!s1_valid_s1 || adv) begin
			s1_byte_s1  <= image_byte;
			s1_final_s1 <= final_byte;
		end
	end

	// Scan state. Once a match is held, later bytes are dropped until the final one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 3'd0;
			made_q <= 1'b0;
			kind_q <= KIND_NONE;
		end else if (adv) begin
			if (s1_final_s1) begin
				fill_q <= 3'd0;
				made_q <= 1'b0;
				kind_q <= KIND_NONE;
			end else if (!made_q) begin
				fill_q <= (count == 3'(WinDepth)) ? 3'(HoldDepth) : count;
				if (hit != KIND_NONE) begin
					made_q <= 1'b1;
					kind_q <= hit;
				end
			end
		end
	end

	// Hold the unfinished bytes; on a full window the oldest position has been tested, so slide by one.
	always_ff @(posedge clk) begin
		if (adv && !s1_final_s1 && !made_q) begin
			for (int i = 0; i < HoldDepth; i++)
				win_q[i] <= (count == 3'(WinDepth)) ? cur[i + 1] : cur[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && s1_final_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_final_s1) begin
			found_q    <= made_q || (hit != KIND_NONE);
			res_kind_q <= made_q ? kind_q : hit;
		end
	end

	assign res_valid = res_valid_q;
	assign found     = found_q;
	assign save_kind = res_kind_q;

endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for save_signature_scanner_unit: streams byte images and
// checks each per-image verdict against an in-bench scanner. Depends on sss_pkg.
`timescale 1ns / 1ps
module tb;
	import sss_pkg::*;

	// Quiet cycles (no transfer on either side) tolerated before giving up.
	// Worst legal stretch is the long receiver hold below plus a long gap.
	localparam int unsigned QuietLimit = 5000;
	localparam int unsigned HoldCycles = 400;
	// The directed images produce this many verdicts; the long hold starts after them.
	localparam int unsigned DirectedVerdicts = 6;
	localparam int unsigned StreamBytes = 1950;

	typedef struct packed {
		byte_t data;
		logic  last;
	} stream_item_t;

	typedef struct packed {
		logic       hit;
		save_kind_t kind;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       src_valid = 1'b0;
	logic       src_stall;
	logic [7:0] image_byte = 8'h00;
	logic       final_byte = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic       found;
	logic [2:0] save_kind;

	save_signature_scanner_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.image_byte (image_byte),
		.final_byte (final_byte),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.found      (found),
		.save_kind  (save_kind)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Scanner model: its own six-byte window, fill count and sticky
	// first-match record, cleared after every final byte.
	// ---------------------------------------------------------------
	byte_t       scan_win [0:WinDepth-1];
	int unsigned scan_fill;
	bit          scan_hit;
	save_kind_t  scan_kind;

	stream_item_t image_stream [$];
	verdict_t     verdicts_due [$];

	int unsigned errors = 0;
	int unsigned cyc = 0;
	int unsigned quiet = 0;
	bit          timed_out = 1'b0;

	function automatic void clear_scan();
		for (int i = 0; i < WinDepth; i++)
			scan_win[i] = 8'h00;
		scan_fill = 0;
		scan_hit = 1'b0;
		scan_kind = KIND_NONE;
	endfunction

	// Signature test at window slot pos, with avail bytes present from pos on.
	function automatic save_kind_t sig_at(int unsigned pos, int unsigned avail);
		save_kind_t k;
		k = KIND_NONE;
		if (avail == 0 || pos + avail > WinDepth)
			return KIND_NONE;
		case (scan_win[pos])
			CH_E: if (avail >= 6 && scan_win[pos+1] == CH_E && scan_win[pos+2] == CH_P &&
					scan_win[pos+3] == CH_R && scan_win[pos+4] == CH_O &&
					scan_win[pos+5] == CH_M)
				k = KIND_EEPROM_8K;
			CH_S: if (avail >= 4 && scan_win[pos+1] == CH_R && scan_win[pos+2] == CH_A &&
					scan_win[pos+3] == CH_M)
				k = KIND_SRAM_32K;
			CH_F: if (avail >= 5 && scan_win[pos+1] == CH_L && scan_win[pos+2] == CH_A &&
					scan_win[pos+3] == CH_S && scan_win[pos+4] == CH_H) begin
				// size byte may be missing at the end of the image -> 64K
				if (avail >= 6 && scan_win[pos+5] == CH_ONE)
					k = KIND_FLASH_128K;
				else
					k = KIND_FLASH_64K;
			end
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic void record_hit(save_kind_t k);
		if (!scan_hit && k != KIND_NONE) begin
			scan_hit = 1'b1;
			scan_kind = k;
		end
	endfunction

	// Feed one accepted byte; a final byte queues the verdict for the image.
	function automatic void scan_byte(byte_t b, bit last);
		int unsigned pos;
		if (!scan_hit) begin
			if (scan_fill >= WinDepth)
				scan_fill = WinDepth - 1;
			scan_win[scan_fill] = b;
			scan_fill++;
			if (scan_fill == WinDepth) begin
				// oldest start position now has all six bytes behind it
				record_hit(sig_at(0, WinDepth));
				for (int i = 0; i < WinDepth - 1; i++)
					scan_win[i] = scan_win[i+1];
				scan_win[WinDepth-1] = 8'h00;
				scan_fill = WinDepth - 1;
			end
			if (last)
				for (pos = 0; pos < scan_fill && !scan_hit; pos++)
					record_hit(sig_at(pos, scan_fill - pos));
		end
		if (last) begin
			verdicts_due.push_back('{hit: scan_hit, kind: scan_kind});
			clear_scan();
		end
	endfunction

	// ---------------------------------------------------------------
	// Stimulus building
	// ---------------------------------------------------------------
	string sigs [5] = '{"EEPROM", "SRAM", "FLASH1", "FLASH5", "FLASH"};
	string letters = "EPROMSRAFLH15";

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			image_stream.push_back('{data: s[i], last: (i == s.len() - 1)});
	endtask

	// Random image: noise, signature letters and whole or cut-short signatures.
	task automatic add_random_image(input int unsigned len);
		byte_t       img [$];
		string       frag;
		int unsigned cut;
		int unsigned r;
		while (img.size() < len) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				img.push_back(byte_t'($urandom_range(0, 255)));
			end else if (r < 65) begin
				img.push_back(letters[$urandom_range(0, letters.len() - 1)]);
			end else begin
				frag = sigs[$urandom_range(0, 4)];
				cut = ($urandom_range(0, 2) == 0) ? $urandom_range(1, frag.len()) : frag.len();
				for (int i = 0; i < cut; i++)
					img.push_back(frag[i]);
			end
		end
		foreach (img[i])
			image_stream.push_back('{data: img[i], last: (i == img.size() - 1)});
	endtask

	// Gap length: mostly none or short, now and then long. At the start of each
	// repeating period of the cycle count there is a window with no idling at all.
	function automatic int unsigned pause_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if ((cyc % 600) < 150 || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// ---------------------------------------------------------------
	// Source driver: offers the next queued byte, holds it while stalled,
	// then idles for a random gap after each transfer.
	// ---------------------------------------------------------------
	int unsigned src_idle = 0;
	stream_item_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			image_byte <= 8'h00;
			final_byte <= 1'b0;
			src_idle = 0;
		end else begin
			if (src_valid && !src_stall)
				scan_byte(image_byte, final_byte);
			// payload may only move when nothing is offered or the offer was taken
			if (!src_valid || !src_stall) begin
				if (src_idle > 0) begin
					src_idle--;
					src_valid <= 1'b0;
				end else if (image_stream.size() != 0) begin
					next_item = image_stream.pop_front();
					image_byte <= next_item.data;
					final_byte <= next_item.last;
					src_valid <= 1'b1;
					src_idle = pause_len();
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Result monitor: checks each verdict transfer against the oldest
	// queued verdict and drives res_stall. Once the directed verdicts are
	// in, it holds off for a long stretch so the block backs up and
	// stalls its input while the source keeps offering.
	// ---------------------------------------------------------------
	int unsigned verdicts_seen = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;
	bit          hold_done = 1'b0;
	verdict_t    due;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				verdicts_seen++;
				if (verdicts_due.size() == 0) begin
					errors++;
					$display("%0t: verdict with none pending: found %0d save_kind %0d",
						$time, found, save_kind);
				end else begin
					due = verdicts_due.pop_front();
					if (found !== due.hit) begin
						errors++;
						$display("%0t: found expected %0d actual %0d", $time, due.hit, found);
					end
					if (save_kind !== due.kind) begin
						errors++;
						$display("%0t: save_kind expected %0d actual %0d",
							$time, due.kind, save_kind);
					end
				end
			end
			if (!hold_done && verdicts_seen >= DirectedVerdicts) begin
				hold_done = 1'b1;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				stall_left = pause_len();
			end
		end
	end

	// Watchdog: counts cycles with no transfer on either side.
	always @(posedge clk) begin
		cyc++;
		if ((src_valid && !src_stall) || (res_valid && !res_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QuietLimit)
			timed_out = 1'b1;
	end

	initial begin
		clear_scan();
		// directed: single-byte images at both byte extremes, then each
		// signature filling the image exactly; a bare FLASH at the end has
		// no size byte and must read as 64K
		image_stream.push_back('{data: 8'h00, last: 1'b1});
		image_stream.push_back('{data: 8'hFF, last: 1'b1});
		add_text("EEPROM");
		add_text("SRAM");
		add_text("FLASH1");
		add_text("FLASH");
		// burst of tiny images so the long receiver hold backs up the block
		repeat (30)
			add_random_image($urandom_range(1, 3));
		while (image_stream.size() < StreamBytes)
			add_random_image(($urandom_range(0, 99) < 85) ?
				$urandom_range(1, 24) : $urandom_range(1, 64));

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// checked mid-cycle so the driver and monitor updates of the edge have settled
		while (!timed_out &&
				(image_stream.size() != 0 || src_valid || verdicts_due.size() != 0))
			@(negedge clk);

		if (timed_out) begin
			$display("end of test: mismatches");
		end else begin
			// wait on to catch any stray verdict
			repeat (8) @(posedge clk);
			if (errors == 0)
				$display("end of test: clean");
			else
				$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
